// File: rtl/wtc_pkg.sv
// ----------------------------------------------------------------------------
// wtc_pkg
// Shared constants and controller/datapath interface types for the wavelet
// template correlator.
// ----------------------------------------------------------------------------
package wtc_pkg;

    localparam int TAPS        = 21;
    localparam int SAMPLE_BITS = 16;
    localparam int HALF        = TAPS / 2;

    localparam int COEF_BITS   = 16;
    localparam int IDX_BITS    = 5;
    localparam int CORR_BITS   = 40;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;

    localparam int TAP_IDX_W   = $clog2(TAPS);
    localparam int TAP_CNT_W   = $clog2(TAPS + 1);
    localparam int CNT_W       = $clog2(HALF + 2);
    localparam int FLUSH_W     = $clog2(HALF + 1);
    localparam int SUM_W       = $clog2(2 * HALF + 2);

    // Stream payload layout
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 40;
    localparam int SAMPLE_LSB   = 0;
    localparam int COEF_IDX_LSB = 16;
    localparam int COEF_VAL_LSB = 21;

    // Request kinds carried on s_tuser
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef struct packed {
        logic                 win_shift;
        logic                 win_zero;
        logic                 win_clear;
        logic                 coef_wr;
        logic                 mac_load;
        logic                 acc_clear;
        logic                 acc_add;
        logic [TAP_IDX_W-1:0] tap_idx;
        logic                 out_load;
        logic                 out_last;
    } wtc_cmd_t;

    typedef struct packed {
        logic out_free;
    } wtc_sts_t;

endpackage

// File: rtl/wtc_datapath.sv
// ----------------------------------------------------------------------------
// wtc_datapath
// Sample delay line, template store, shared multiply-accumulate unit and
// output register.
// ----------------------------------------------------------------------------
module wtc_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wtc_pkg::wtc_cmd_t                   cmd,
    output wtc_pkg::wtc_sts_t                   sts,
    input  logic [15:0]                         in_sample,
    input  logic [wtc_pkg::IDX_BITS-1:0]        in_coef_index,
    input  logic [wtc_pkg::COEF_BITS-1:0]       in_coef_value,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wtc_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);
    import wtc_pkg::*;

    logic signed [SAMPLE_BITS-1:0] win_reg  [TAPS];
    logic signed [COEF_BITS-1:0]   tmpl_reg [TAPS];
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [CORR_BITS-1:0]   acc_reg;
    logic [SAMPLE_BITS+15:0]       sample_ext;
    logic [SAMPLE_BITS-1:0]        win_in;
    logic [TAP_IDX_W+IDX_BITS-1:0] ci_ext;
    logic [TAP_IDX_W-1:0]          mirror_idx;
    logic                          m_tvalid_reg;
    logic [CORR_BITS-1:0]          m_tdata_reg;
    logic                          m_tlast_reg;

    // Take the low SAMPLE_BITS of the zero-extended field
    assign sample_ext = {{SAMPLE_BITS{1'b0}}, in_sample};
    assign win_in     = cmd.win_zero ? '0 : sample_ext[SAMPLE_BITS-1:0];
    assign ci_ext     = {{TAP_IDX_W{1'b0}}, in_coef_index};
    assign mirror_idx = TAP_IDX_W'(TAPS - 1) - cmd.tap_idx;
    assign prod_next  = win_reg[cmd.tap_idx] * tmpl_reg[mirror_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.win_clear) begin
            for (int i = 0; i < TAPS; i++) win_reg[i] <= '0;
        end else if (cmd.win_shift) begin
            for (int i = 1; i < TAPS; i++) win_reg[i] <= win_reg[i-1];
            win_reg[0] <= win_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++) tmpl_reg[i] <= '0;
        end else if (cmd.coef_wr && (ci_ext < (TAP_IDX_W + IDX_BITS)'(TAPS))) begin
            tmpl_reg[ci_ext[TAP_IDX_W-1:0]] <= in_coef_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mac_load) prod_reg <= prod_next;
        if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + CORR_BITS'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= acc_reg;
            m_tlast_reg <= cmd.out_last;
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign m_tlast      = m_tlast_reg;

endmodule

// File: rtl/wtc_ctrl.sv
// ----------------------------------------------------------------------------
// wtc_ctrl
// Sequencer: takes requests, runs the tap loop per point, drives the flush.
// ----------------------------------------------------------------------------
module wtc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output wtc_pkg::wtc_cmd_t     cmd,
    input  wtc_pkg::wtc_sts_t     sts
);
    import wtc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DONE  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [TAP_CNT_W-1:0] tap_reg,   tap_next;
    logic [CNT_W-1:0]     cnt_reg,   cnt_next;
    logic [FLUSH_W-1:0]   flush_reg, flush_next;
    logic                 last_reg,  last_next;
    logic                 rlast_reg, rlast_next;
    logic                 accept;
    logic [SUM_W-1:0]     flush_sum;
    logic [FLUSH_W-1:0]   flush_inc;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign flush_inc = flush_reg + FLUSH_W'(1);
    assign flush_sum = SUM_W'(cnt_reg) + SUM_W'(flush_inc);

    always_comb begin
        state_next = state_reg;
        tap_next   = tap_reg;
        cnt_next   = cnt_reg;
        flush_next = flush_reg;
        last_next  = last_reg;
        rlast_next = rlast_reg;
        cmd        = '0;
        cmd.tap_idx = tap_reg[TAP_IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser == REQ_COEF) begin
                        cmd.coef_wr = 1'b1;
                    end else begin
                        cmd.win_shift = 1'b1;
                        flush_next    = '0;
                        last_next     = s_tlast;
                        rlast_next    = 1'b0;
                        if (cnt_reg < CNT_W'(HALF + 1)) cnt_next = cnt_reg + CNT_W'(1);
                        if (cnt_reg >= CNT_W'(HALF)) begin
                            tap_next   = '0;
                            state_next = S_MAC;
                        end else if (s_tlast) begin
                            state_next = S_FLUSH;
                        end
                    end
                end
            end
            S_MAC: begin
                // prod for tap j lands while tap j-1 is summed
                cmd.mac_load  = (tap_reg < TAP_CNT_W'(TAPS));
                cmd.acc_clear = (tap_reg == '0);
                cmd.acc_add   = (tap_reg != '0);
                tap_next      = tap_reg + TAP_CNT_W'(1);
                if (tap_reg == TAP_CNT_W'(TAPS)) state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = rlast_reg;
                    if (last_reg && (flush_reg < FLUSH_W'(HALF))) begin
                        state_next = S_FLUSH;
                    end else begin
                        if (last_reg) begin
                            cmd.win_clear = 1'b1;
                            cnt_next      = '0;
                            last_next     = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                cmd.win_shift = 1'b1;
                cmd.win_zero  = 1'b1;
                flush_next    = flush_inc;
                if (flush_sum > SUM_W'(HALF)) begin
                    rlast_next = (flush_inc == FLUSH_W'(HALF));
                    tap_next   = '0;
                    state_next = S_MAC;
                end else if (flush_inc == FLUSH_W'(HALF)) begin
                    cmd.win_clear = 1'b1;
                    cnt_next      = '0;
                    last_next     = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
            cnt_reg   <= '0;
            flush_reg <= '0;
            last_reg  <= 1'b0;
            rlast_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
            last_reg  <= last_next;
            rlast_reg <= rlast_next;
        end
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("output register loaded while still occupied");

    a_mac_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC) && (tap_reg == TAP_CNT_W'(TAPS)) |=> (state_reg == S_DONE))
        else $error("tap loop did not end after the last tap");

    a_flush_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (flush_reg <= FLUSH_W'(HALF)) && (cnt_reg <= CNT_W'(HALF + 1)))
        else $error("flush or sample count out of range");

    a_flush_only_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH) |-> last_reg)
        else $error("flush running without a final sample");
`endif

endmodule

// File: rtl/wavelet_template_correlator_core.sv
// ----------------------------------------------------------------------------
// wavelet_template_correlator_core
// Streaming 21-point template cross-correlation over signed ECG samples.
// ----------------------------------------------------------------------------
//  channel | dir | ports                               | beat contents
//  --------+-----+-------------------------------------+------------------------
//  input   | in  | s_tvalid s_tready s_tdata s_tuser   | sample or coefficient
//          |     | s_tlast                             | write; tlast ends signal
//  result  | out | m_tvalid m_tready m_tdata m_tlast   | one correlation point
//
//  Points: one shared 16x16 multiply-accumulate unit walks the taps of
//  each produced point, one per cycle. A final sample also flushes up to
//  HALF zero-padded points.
//  Reset: aresetn is synchronous, active low; it clears the delay line,
//  the template and the sample count.
//  Stalls: a held m_tready holds the result in the output register; the
//  sequencer waits only when a new point is ready and the register is full.
// ----------------------------------------------------------------------------
module wavelet_template_correlator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] sample, [20:16] coef_index, [36:21] coef_value, [39:37] zero
    input  logic [wtc_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] req_type
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [39:0] correlation
    output logic [wtc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);
    import wtc_pkg::*;

    wtc_cmd_t cmd;
    wtc_sts_t sts;

    // Sequencer: accepts beats only when idle, steps taps and flush points
    wtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Delay line, template, MAC and output register
    wtc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .in_sample     (s_tdata[SAMPLE_LSB +: 16]),
        .in_coef_index (s_tdata[COEF_IDX_LSB +: IDX_BITS]),
        .in_coef_value (s_tdata[COEF_VAL_LSB +: COEF_BITS]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample and coefficient-write beats into the template correlator.
// Every accepted input beat runs through a local correlator that queues the
// correlation points it should produce. Every result beat is checked against
// the oldest queued point. A short table of directed beats comes first.
// Random signals of mixed length follow, with random template rewrites.
// ----------------------------------------------------------------------------
module testbench;
    import wtc_pkg::*;

    localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int TAIL_CYCLES  = 300;   // covers one full flush of HALF points
    localparam int TARGET_BEATS = 410;

    typedef struct {
        logic        req;
        logic [15:0] smp;
        logic        last;
        logic [4:0]  idx;
        logic [15:0] val;
        logic        typed;   // correlation below is known without the predictor
        logic signed [CORR_BITS-1:0] corr;
    } stim_row_t;

    typedef struct {
        logic signed [CORR_BITS-1:0] corr;
        logic                        last;
    } corr_point_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = REQ_SAMPLE;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // Sideband that travels with the driven beat, updated like the bus.
    logic                        beat_typed      = 1'b0;
    logic signed [CORR_BITS-1:0] beat_typed_corr = '0;

    // Local correlator state
    logic signed [COEF_BITS-1:0]   window_q [TAPS];
    logic signed [COEF_BITS-1:0]   template_q [TAPS];
    int                            seen_count;
    corr_point_t                   pending_points [$];

    int   mismatch_count = 0;
    int   beats_sent     = 0;
    int   quiet_cycles   = 0;
    logic no_idle        = 1'b0;

    // Directed beats: clean reset, template loads, extremes, short signals
    // and a normal-plus-flush signal.
    stim_row_t directed_rows [22] = '{
        // template is all zero after reset, so every point is zero
        '{REQ_SAMPLE, 16'h7FFF, 1'b0, 5'd0,  16'h0000, 1'b1, 40'sd0},
        '{REQ_SAMPLE, 16'h8000, 1'b0, 5'd0,  16'h0000, 1'b1, 40'sd0},
        '{REQ_SAMPLE, 16'h0001, 1'b1, 5'd0,  16'h0000, 1'b1, 40'sd0},
        // coefficient writes ignore sample and tlast
        '{REQ_COEF,   16'hFFFF, 1'b1, 5'd10, 16'h1000, 1'b0, 40'sd0},
        '{REQ_COEF,   16'h0000, 1'b0, 5'd0,  16'h8000, 1'b0, 40'sd0},
        '{REQ_COEF,   16'h0000, 1'b0, 5'd20, 16'h7FFF, 1'b0, 40'sd0},
        // indexes past the template are dropped
        '{REQ_COEF,   16'h0000, 1'b0, 5'd21, 16'h1234, 1'b0, 40'sd0},
        '{REQ_COEF,   16'hFFFF, 1'b1, 5'd31, 16'hFFFF, 1'b0, 40'sd0},
        // one-sample signals: only the center tap (1.0) sees the sample
        '{REQ_SAMPLE, 16'h7FFF, 1'b1, 5'd0,  16'h0000, 1'b1, 40'sd134213632},
        '{REQ_SAMPLE, 16'h8000, 1'b1, 5'd0,  16'h0000, 1'b1, -40'sd134217728},
        // twelve samples: regular points, then the flush
        '{REQ_SAMPLE, 16'h7FFF, 1'b0, 5'd0,  16'h0000, 1'b0, 40'sd0},
        '{REQ_SAMPLE, 16'h8000, 1'b0, 5'd0,  16'h0000, 1'b0, 40'sd0},
        '{REQ_SAMPLE, 16'h0000, 1'b0, 5'd0,  16'h0000, 1'b0, 40'sd0},
        '{REQ_SAMPLE, 16'hFFFF, 1'b0, 5'd0,  16'h0000, 1'b0, 40'sd0},
        '{REQ_SAMPLE, 16'h7FFF, 1'b0, 5'd0,  16'h0000, 1'b0, 40'sd0},
        '{REQ_SAMPLE, 16'h7FFF, 1'b0, 5'd0,  16'h0000, 1'b0, 40'sd0},
        '{REQ_SAMPLE, 16'h8000, 1'b0, 5'd0,  16'h0000, 1'b0, 40'sd0},
        '{REQ_SAMPLE, 16'h8000, 1'b0, 5'd0,  16'h0000, 1'b0, 40'sd0},
        '{REQ_SAMPLE, 16'h1234, 1'b0, 5'd0,  16'h0000, 1'b0, 40'sd0},
        '{REQ_SAMPLE, 16'hEDCB, 1'b0, 5'd0,  16'h0000, 1'b0, 40'sd0},
        '{REQ_SAMPLE, 16'h7FFF, 1'b0, 5'd0,  16'h0000, 1'b0, 40'sd0},
        '{REQ_SAMPLE, 16'h8000, 1'b1, 5'd0,  16'h0000, 1'b0, 40'sd0}
    };

    wavelet_template_correlator_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Local correlator
    // ------------------------------------------------------------------------
    function automatic logic signed [CORR_BITS-1:0] window_dot();
        logic signed [63:0] acc;
        acc = '0;
        // newest sample sits at window index 0 and meets the last tap
        for (int j = 0; j < TAPS; j++) begin
            acc = acc + window_q[j] * template_q[TAPS-1-j];
        end
        return acc[CORR_BITS-1:0];
    endfunction

    function automatic void shift_window(logic signed [COEF_BITS-1:0] v);
        for (int i = TAPS - 1; i > 0; i--) begin
            window_q[i] = window_q[i-1];
        end
        window_q[0] = v;
    endfunction

    task automatic correlate_beat(input logic req, input logic signed [15:0] smp,
                                  input logic last, input logic [4:0] idx,
                                  input logic signed [15:0] val);
        corr_point_t pt;
        if (req == REQ_COEF) begin
            if (idx < TAPS) begin
                template_q[idx] = val;
            end
            return;
        end
        shift_window(smp);
        if (seen_count >= HALF) begin
            pt.corr = window_dot();
            pt.last = 1'b0;
            pending_points.push_back(pt);
        end
        if (seen_count < HALF + 1) begin
            seen_count++;
        end
        if (last) begin
            // flush the trailing points against zero padding
            for (int k = 1; k <= HALF; k++) begin
                shift_window('0);
                if (seen_count + k > HALF) begin
                    pt.corr = window_dot();
                    pt.last = (k == HALF);
                    pending_points.push_back(pt);
                end
            end
            foreach (window_q[i]) window_q[i] = '0;
            seen_count = 0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: predict on every input beat, check every result beat, and
    // watch for a hang.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        int          n0;
        corr_point_t exp_pt;
        if (aresetn) begin
            quiet_cycles++;
            if (s_tvalid && s_tready) begin
                quiet_cycles = 0;
                n0 = pending_points.size();
                correlate_beat(s_tuser, s_tdata[15:0], s_tlast, s_tdata[20:16],
                               s_tdata[36:21]);
                // directed rows with a known answer override the prediction
                if (beat_typed) begin
                    for (int i = n0; i < pending_points.size(); i++) begin
                        pending_points[i].corr = beat_typed_corr;
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                quiet_cycles = 0;
                if (pending_points.size() == 0) begin
                    report_mismatch($sformatf("unexpected result corr=%0d last=%0b",
                                              $signed(m_tdata), m_tlast));
                end else begin
                    exp_pt = pending_points.pop_front();
                    if ($signed(m_tdata) !== exp_pt.corr) begin
                        report_mismatch($sformatf("correlation got %0d expected %0d",
                                                  $signed(m_tdata), exp_pt.corr));
                    end
                    if (m_tlast !== exp_pt.last) begin
                        report_mismatch($sformatf("tlast got %0b expected %0b",
                                                  m_tlast, exp_pt.last));
                    end
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Result side: stall at random, except during the no-idle stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99, 0) >= 38);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic req, input logic [15:0] smp, input logic last,
                             input logic [4:0] idx, input logic [15:0] val,
                             input logic typed, input logic signed [CORR_BITS-1:0] corr);
        while (!no_idle && $urandom_range(99, 0) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid        <= 1'b1;
        s_tuser         <= req;
        s_tlast         <= last;
        s_tdata         <= {3'b000, val, idx, smp};
        beat_typed      <= typed;
        beat_typed_corr <= corr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(9, 0))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(65535, 0));
        endcase
    endfunction

    task automatic send_coef_write();
        logic [4:0] idx;
        // mostly in range; the rest exercises the dropped indexes
        idx = ($urandom_range(99, 0) < 85) ? 5'($urandom_range(TAPS - 1, 0))
                                           : 5'($urandom_range(31, TAPS));
        send_beat(REQ_COEF, pick_word(), 1'($urandom_range(1, 0)), idx, pick_word(),
                  1'b0, '0);
    endtask

    initial begin
        int   sig_len;
        int   n_coef;
        logic paused_once;
        paused_once = 1'b0;
        foreach (window_q[i]) window_q[i] = '0;
        foreach (template_q[i]) template_q[i] = '0;
        seen_count = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            send_beat(directed_rows[r].req, directed_rows[r].smp, directed_rows[r].last,
                      directed_rows[r].idx, directed_rows[r].val,
                      directed_rows[r].typed, directed_rows[r].corr);
        end

        while (beats_sent < TARGET_BEATS) begin
            // hold off once until every queued point has drained; let a clock edge
            // pass first so the last beat's points are already queued
            if (!paused_once && beats_sent >= 200) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_points.size() != 0) @(posedge aclk);
                paused_once = 1'b1;
            end
            no_idle = (beats_sent >= 250 && beats_sent < 330);

            // rewrite part of the template now and then
            if ($urandom_range(99, 0) < 30) begin
                n_coef = $urandom_range(6, 2);
                repeat (n_coef) send_coef_write();
            end

            case ($urandom_range(9, 0))
                0, 1, 2: sig_len = $urandom_range(HALF, 1);
                9:       sig_len = $urandom_range(80, 41);
                default: sig_len = $urandom_range(40, HALF + 1);
            endcase

            for (int i = 1; i <= sig_len; i++) begin
                if ($urandom_range(99, 0) < 8) begin
                    send_coef_write();
                end
                send_beat(REQ_SAMPLE, pick_word(), (i == sig_len), 5'($urandom_range(31, 0)),
                          16'($urandom_range(65535, 0)), 1'b0, '0);
            end
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        // let a clock edge pass so the last beat's points are queued before waiting
        @(posedge aclk);
        while (pending_points.size() != 0) @(posedge aclk);
        // catch any stray beat that trails the last expected point
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
